[rtl/core/ugle_pkg.sv]
// Shared types, codes and constants for the UTF-8 glyph layout engine.
`timescale 1ns / 1ps

package ugle_pkg;

  // Table geometry and register defaults
  localparam int GLYPH_INDEX_BITS_DEF = 10;
  localparam logic [11:0] LINE_HEIGHT_RST = 12'd16;

  // Operation codes of an input beat
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  // UTF-8 lead nibbles and the newline byte
  localparam logic [3:0] LEAD4_NIB  = 4'hF;
  localparam logic [3:0] LEAD3_NIB  = 4'hE;
  localparam logic [3:0] LEAD2H_NIB = 4'hD;
  localparam logic [3:0] LEAD2L_NIB = 4'hC;
  localparam logic [7:0] NEWLINE    = 8'h0A;

  // Position limits, 24-bit signed fixed point with 8 fraction bits
  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = -24'sh800000;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         text_byte;
    logic [9:0]         glyph_index;
    logic [15:0]        atlas_left;
    logic [15:0]        atlas_top;
    logic [15:0]        atlas_right;
    logic [15:0]        atlas_bottom;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic [11:0]        advance;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
  } text_beat_t;

  typedef struct packed {
    logic signed [23:0] quad_x;
    logic signed [23:0] quad_y;
    logic [15:0]        quad_width;
    logic [15:0]        quad_height;
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic [7:0]         atlas_set;
  } quad_beat_t;

  // One entry of the glyph metrics table
  typedef struct packed {
    logic [15:0]        left;
    logic [15:0]        top;
    logic [15:0]        right;
    logic [15:0]        bottom;
    logic signed [23:0] off_x;
    logic signed [23:0] off_y;
    logic [11:0]        adv;
  } glyph_t;

  // Clamp a 25-bit sum to the 24-bit signed range
  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? POS_MIN : POS_MAX;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/utf8_glyph_layout_engine.sv]
// Top level: UTF-8 decoder, glyph metrics memory and pen update pipeline.
//
//   channel | direction | handshake             | beat
//   text    | in        | text_valid/text_stall | text_beat (ugle_pkg::text_beat_t)
//   quad    | out       | quad_valid/quad_stall | quad_beat (ugle_pkg::quad_beat_t)
//   cfg     | in        | cfg_we                | cfg_data (line_height)
//
// One beat per cycle sustained while the quad channel does not stall.
// A quad leaves after its last byte through the registered glyph memory read, then the pen stage.
// Synchronous reset clears the pen, decoder and handshake state; the glyph
// memory holds no reset value and must be loaded before use.
// A stalled quad holds the pen stage, which then stalls the text channel.
`timescale 1ns / 1ps

module utf8_glyph_layout_engine #(
  parameter int GLYPH_INDEX_BITS = ugle_pkg::GLYPH_INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  ugle_pkg::text_beat_t text_beat,
  output logic                 quad_valid,
  input  logic                 quad_stall,
  output ugle_pkg::quad_beat_t quad_beat,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_data
);
  import ugle_pkg::*;

  localparam int DEPTH = 1 << GLYPH_INDEX_BITS;

  typedef enum logic [1:0] {
    K_NONE,
    K_EMIT,
    K_NEWLINE,
    K_START
  } kind_t;

  // Glyph metrics memory
  glyph_t mem [DEPTH];
  glyph_t rd_data;

  // Decoder state
  logic [20:0] partial;
  logic [1:0]  pend;
  logic [20:0] partial_next;
  logic [1:0]  pend_next;

  // Pen stage
  logic                        s1_valid;
  kind_t                       s1_kind;
  logic [7:0]                  s1_set;
  logic signed [23:0]          s1_sx;
  logic signed [23:0]          s1_sy;
  logic signed [23:0]          pen_x;
  logic signed [23:0]          pen_y;
  logic signed [23:0]          line_start_x;
  logic [11:0]                 line_height;

  logic                        text_acc;
  logic                        s1_go;
  logic                        out_free;
  kind_t                       kind_next;
  logic [20:0]                 cp_next;
  logic [GLYPH_INDEX_BITS-1:0] rd_addr;
  logic [GLYPH_INDEX_BITS-1:0] wr_addr;

  logic signed [23:0]          qx;
  logic signed [23:0]          qy;
  logic signed [23:0]          px_adv;
  logic signed [23:0]          py_nl;
  logic [15:0]                 qw;
  logic [15:0]                 qh;

  assign out_free   = !quad_valid || !quad_stall;
  assign s1_go      = s1_valid && out_free;
  assign text_stall = s1_valid && !out_free;
  assign text_acc   = text_valid && !text_stall;

  // Decode one byte and pick the pen action
  always_comb begin
    partial_next = partial;
    pend_next    = pend;
    kind_next    = K_NONE;
    cp_next      = {13'd0, text_beat.text_byte};
    case (text_beat.op)
      OP_START: begin
        partial_next = '0;
        pend_next    = '0;
        kind_next    = K_START;
      end
      OP_TEXT: begin
        if (pend != 2'd0) begin
          cp_next   = {partial[14:0], text_beat.text_byte[5:0]};
          pend_next = pend - 2'd1;
          if (pend == 2'd1) begin
            partial_next = '0;
            kind_next    = K_EMIT;
          end else begin
            partial_next = cp_next;
          end
        end else if (text_beat.text_byte == NEWLINE) begin
          kind_next = K_NEWLINE;
        end else begin
          case (text_beat.text_byte[7:4])
            LEAD4_NIB: begin
              partial_next = {18'd0, text_beat.text_byte[2:0]};
              pend_next    = 2'd3;
            end
            LEAD3_NIB: begin
              partial_next = {17'd0, text_beat.text_byte[3:0]};
              pend_next    = 2'd2;
            end
            LEAD2H_NIB, LEAD2L_NIB: begin
              partial_next = {16'd0, text_beat.text_byte[4:0]};
              pend_next    = 2'd1;
            end
            default: begin
              kind_next = K_EMIT;
            end
          endcase
        end
      end
      default: begin
        kind_next = K_NONE;
      end
    endcase
  end

  assign rd_addr = cp_next[GLYPH_INDEX_BITS-1:0];
  assign wr_addr = (GLYPH_INDEX_BITS)'(text_beat.glyph_index);

  // Write loaded entries, read the glyph for each finished codepoint
  always_ff @(posedge clk) begin
    if (text_acc && text_beat.op == OP_LOAD) begin
      mem[wr_addr] <= '{left:   text_beat.atlas_left,
                        top:    text_beat.atlas_top,
                        right:  text_beat.atlas_right,
                        bottom: text_beat.atlas_bottom,
                        off_x:  text_beat.offset_x,
                        off_y:  text_beat.offset_y,
                        adv:    text_beat.advance};
    end
    if (text_acc && kind_next == K_EMIT) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold decoder state and the pen stage payload
  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= '0;
      pend     <= '0;
      s1_valid <= 1'b0;
      s1_kind  <= K_NONE;
    end else begin
      if (text_acc) begin
        partial  <= partial_next;
        pend     <= pend_next;
        s1_valid <= 1'b1;
        s1_kind  <= kind_next;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_set <= cp_next[15:8];
      s1_sx  <= text_beat.start_x;
      s1_sy  <= text_beat.start_y;
    end
  end

  // Quad geometry and pen sums
  assign qx     = sat24(25'(pen_x) + 25'(rd_data.off_x));
  assign qy     = sat24(25'(pen_y) + 25'(rd_data.off_y));
  assign px_adv = sat24(25'(pen_x) + $signed({5'd0, rd_data.adv, 8'd0}));
  assign py_nl  = sat24(25'(pen_y) + $signed({5'd0, line_height, 8'd0}));
  assign qw = (rd_data.right >= rd_data.left) ? rd_data.right - rd_data.left : 16'd0;
  assign qh = (rd_data.bottom >= rd_data.top) ? rd_data.bottom - rd_data.top : 16'd0;

  // Advance the pen and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
      line_height  <= LINE_HEIGHT_RST;
      quad_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_height <= cfg_data;
      end
      if (s1_go) begin
        case (s1_kind)
          K_EMIT: begin
            pen_x <= px_adv;
          end
          K_NEWLINE: begin
            pen_x <= line_start_x;
            pen_y <= py_nl;
          end
          K_START: begin
            pen_x        <= s1_sx;
            line_start_x <= s1_sx;
            pen_y        <= s1_sy;
          end
          default: begin
            pen_x <= pen_x;
          end
        endcase
      end
      if (s1_go && s1_kind == K_EMIT) begin
        quad_valid <= 1'b1;
      end else if (!quad_stall) begin
        quad_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_kind == K_EMIT) begin
      quad_beat <= '{quad_x:      qx,
                     quad_y:      qy,
                     quad_width:  qw,
                     quad_height: qh,
                     src_x:       rd_data.left,
                     src_y:       rd_data.top,
                     atlas_set:   s1_set};
    end
  end

  // The input only stalls behind an occupied pen stage
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> s1_valid)
    else $error("text stalled with an empty pen stage");

  // A held pen stage keeps its glyph data
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(rd_data) && $stable(s1_kind))
    else $error("pen stage changed while stalled");

  // A new quad comes only from a glyph action in the pen stage
  a_quad_source: assert property (@(posedge clk) disable iff (rst)
    $rose(quad_valid) |-> $past(s1_go) && $past(s1_kind) == K_EMIT)
    else $error("quad without a glyph action");

  // A string start drops any partial sequence
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    text_acc && text_beat.op == OP_START |=> pend == 2'd0 && partial == 21'd0)
    else $error("decoder not cleared by string start");

endmodule
